/* rtl/spr_pkg.sv */
// Shared types and constants for the stream pattern replace block.
// Used by every module under rtl; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_REPLACE_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int LEN_W       = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_REPLACE_LOW  = 3'd2,
    REG_REPLACE_HIGH = 3'd3,
    REG_PATTERN_LEN  = 3'd4,
    REG_REPLACE_LEN  = 3'd5
  } reg_index_t;

  // Byte 0 sits in bits 7:0; the high register fills bits 127:64.
  typedef struct packed {
    logic [2*CFG_DATA_W-1:0] pattern_bytes;
    logic [2*CFG_DATA_W-1:0] replace_bytes;
    logic [LEN_W-1:0]        pattern_length;
    logic [LEN_W-1:0]        replace_length;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/spr_front.sv */
// Front end: accepts source bytes, keeps the match window and turns each
// item into at most one output command (a byte vector and a count). Uses spr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spr_front #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACE = spr_pkg::MAX_REPLACE_DEF,
  localparam int OUT_BYTES  = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE,
  localparam int OUT_W      = OUT_BYTES * 8,
  localparam int CNT_W      = $clog2(OUT_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spr_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   in_stall,
  input  wire logic              q_full,
  output logic                   push_valid,
  output logic [OUT_W-1:0]       push_bytes,
  output logic [CNT_W-1:0]       push_count,
  output logic                   push_last
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int RLEN_W = $clog2(MAX_REPLACE + 1);
  localparam int WIN_W  = MAX_PATTERN * 8;
  localparam logic [spr_pkg::LEN_W-1:0] PAT_MAX = spr_pkg::LEN_W'(MAX_PATTERN);
  localparam logic [spr_pkg::LEN_W-1:0] REP_MAX = spr_pkg::LEN_W'(MAX_REPLACE);

  logic [7:0]        win      [MAX_PATTERN];
  logic [7:0]        win_next [MAX_PATTERN];
  logic [7:0]        ext      [MAX_PATTERN];
  logic [FILL_W-1:0] fill, fill_next;
  logic [FILL_W-1:0] ext_fill, drop, plen;
  logic [RLEN_W-1:0] rlen;
  logic [WIN_W-1:0]  ext_flat, shift_flat;
  logic [MAX_PATTERN-1:0] eq;
  logic              pass, hit, full_win, accept;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  always_comb begin
    plen = (cfg.pattern_length > PAT_MAX) ? FILL_W'(MAX_PATTERN)
                                          : cfg.pattern_length[FILL_W-1:0];
    rlen = (cfg.replace_length > REP_MAX) ? RLEN_W'(MAX_REPLACE)
                                          : cfg.replace_length[RLEN_W-1:0];
    pass = (plen == '0) || (rlen == '0);
  end

  // Window with the new byte appended at the fill position.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      ext[i] = (FILL_W'(i) == fill) ? in_byte : win[i];
      ext_flat[i*8 +: 8] = ext[i];
      eq[i] = (ext[i] == cfg.pattern_bytes[i*8 +: 8]) || (FILL_W'(i) >= plen);
    end
  end

  assign ext_fill   = fill + 1'b1;
  assign full_win   = ext_fill >= plen;
  assign drop       = ext_fill - (plen - 1'b1);
  assign shift_flat = ext_flat >> {drop, 3'b000};
  // A shrunk pattern length leaves a stale window: no match test then.
  assign hit = !pass && (fill < plen) && (ext_fill == plen) && (&eq);

  always_comb begin
    push_bytes = OUT_W'(ext_flat);
    push_count = '0;
    fill_next  = ext_fill;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_next[i] = ext[i];
    end
    if (pass || (!hit && in_last)) begin
      // flush the whole window including the new byte
      push_count = CNT_W'(ext_fill);
      fill_next  = '0;
    end else if (hit) begin
      push_bytes = OUT_W'(cfg.replace_bytes[MAX_REPLACE*8-1:0]);
      push_count = CNT_W'(rlen);
      fill_next  = '0;
    end else if (full_win) begin
      // emit the oldest bytes, keep the newest plen-1
      push_count = CNT_W'(drop);
      fill_next  = plen - 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_next[i] = shift_flat[i*8 +: 8];
      end
    end
  end

  assign push_valid = accept && (push_count != '0);
  assign push_last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/spr_queue.sv */
// Short command queue between the front end and the output sequencer.
// Generic width; depth default from spr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spr_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = spr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/spr_back.sv */
// Back end: walks the head command one byte per cycle, unless out_stall
// holds it, into the output register. Uses spr_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module spr_back #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACE = spr_pkg::MAX_REPLACE_DEF,
  localparam int OUT_BYTES  = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE,
  localparam int OUT_W      = OUT_BYTES * 8,
  localparam int CNT_W      = $clog2(OUT_BYTES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire logic [OUT_W-1:0] head_bytes,
  input  wire logic [CNT_W-1:0] head_count,
  input  wire logic             head_last,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  localparam int POS_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

  logic [POS_W-1:0] pos;
  logic             load, cmd_done;

  assign load     = head_valid && (!out_valid || !out_stall);
  assign cmd_done = (CNT_W'(pos) == head_count - 1'b1);
  assign pop      = load && cmd_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= head_valid;
      end
      if (load) begin
        pos <= cmd_done ? '0 : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head_bytes[pos*8 +: 8];
      out_last <= head_last && cmd_done;
    end
  end

endmodule

`default_nettype wire

/* rtl/stream_pattern_replace_top.sv */
// Top level of the streaming find-and-replace block: configuration
// registers, front end, command queue and output sequencer. Uses spr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one source byte per cycle unless in_stall is high and gives one
// rewritten byte per cycle unless out_stall is high. The front end
// decides each byte in the cycle it is accepted and may queue a command
// of up to OUT_BYTES bytes; the output sequencer drains commands byte by
// byte, so a match yields replace_length bytes and a final byte that ends
// no match flushes each byte held plus itself. A command is written into
// the queue, then loaded into the output register before its first byte
// is offered on out_valid. The input stalls only when the command queue
// (QUEUE_DEPTH entries) is full. Bytes held in the window appear at the
// output once a later byte pushes them out or the final byte flushes
// them. Write configuration only while the block is idle.
module stream_pattern_replace_top #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACE = spr_pkg::MAX_REPLACE_DEF,
  parameter int QUEUE_DEPTH = spr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [spr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [spr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             in_last,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  out_last
);

  localparam int OUT_BYTES = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int OUT_W     = OUT_BYTES * 8;
  localparam int CNT_W     = $clog2(OUT_BYTES + 1);
  localparam int CMD_W     = OUT_W + CNT_W + 1;
  localparam int DW        = spr_pkg::CFG_DATA_W;

  spr_pkg::cfg_t    cfg;
  logic             q_full, q_empty, q_push, q_pop;
  logic [OUT_W-1:0] push_bytes, head_bytes;
  logic [CNT_W-1:0] push_count, head_count;
  logic             push_last, head_last;
  logic [CMD_W-1:0] push_data, head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        spr_pkg::REG_PATTERN_LOW:  cfg.pattern_bytes[DW-1:0]    <= cfg_data;
        spr_pkg::REG_PATTERN_HIGH: cfg.pattern_bytes[2*DW-1:DW] <= cfg_data;
        spr_pkg::REG_REPLACE_LOW:  cfg.replace_bytes[DW-1:0]    <= cfg_data;
        spr_pkg::REG_REPLACE_HIGH: cfg.replace_bytes[2*DW-1:DW] <= cfg_data;
        spr_pkg::REG_PATTERN_LEN:  cfg.pattern_length <= cfg_data[spr_pkg::LEN_W-1:0];
        spr_pkg::REG_REPLACE_LEN:  cfg.replace_length <= cfg_data[spr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  spr_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push_valid (q_push),
    .push_bytes (push_bytes),
    .push_count (push_count),
    .push_last  (push_last)
  );

  assign push_data = {push_bytes, push_count, push_last};
  assign {head_bytes, head_count, head_last} = head_data;

  spr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (head_data),
    .empty     (q_empty)
  );

  spr_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_empty),
    .head_bytes (head_bytes),
    .head_count (head_count),
    .head_last  (head_last),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (push_count != '0))
    else $error("empty command pushed");

  a_out_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!q_empty))
    else $error("output raised with no queued command");

endmodule

`default_nettype wire
